/* rtl/stop_wait_receiver_checksum_unit_macros.svh */
// Assertion macros shared by the RTL files of the receiver.
// Defining NO_ASSERTIONS removes every assertion from the build.
`ifndef STOP_WAIT_RECEIVER_CHECKSUM_UNIT_MACROS_SVH
`define STOP_WAIT_RECEIVER_CHECKSUM_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define SWRC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("swrc assertion failed");
// Checked at every edge, reset included.
`define SWRC_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("swrc assertion failed");
`else
`define SWRC_ASSERT(name, clk, rst_n, prop)
`define SWRC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

/* rtl/swrc_pkg.sv */
`default_nettype none

package swrc_pkg;

    localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 1024;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned SUM_W   = 16;
    // Seven 16-bit terms at most go into one wide add.
    localparam int unsigned WIDE_W  = SUM_W + 3;

    localparam logic [SUM_W-1:0] SUM_ONES  = 16'hffff;
    localparam logic [SUM_W-1:0] SEQ_RESET = 16'd1;
    localparam logic [SUM_W-1:0] ODD_MASK  = 16'hff00;

    typedef enum logic [1:0] {
        V_COMMIT   = 2'd0,
        V_DUP      = 2'd1,
        V_CSUM_ERR = 2'd2,
        V_AHEAD    = 2'd3
    } t_verdict;

    typedef struct packed {
        logic               first_item;
        logic [15:0]        pkt_seq;
        logic [15:0]        sync_word;
        logic [15:0]        ack_word;
        logic [COUNT_W-1:0] byte_count;
        logic [15:0]        check_word;
        logic [15:0]        retry_word;
        logic               data_valid;
        logic [15:0]        data_word;
        logic               last_item;
    } t_in_word;

    typedef struct packed {
        logic [15:0] data_out;
        logic        data_out_valid;
        logic        packet_end;
        t_verdict    verdict;
        logic        ack_valid;
        logic [15:0] ack_seq;
    } t_out_word;

    // Two end-around-carry folds bring a sum of up to seven 16-bit terms
    // back to 16 bits with the same ones' complement value.
    function automatic logic [SUM_W-1:0] fold_sum(input logic [WIDE_W-1:0] x);
        logic [SUM_W:0] s1;
        logic [SUM_W:0] s2;
        s1 = {1'b0, x[SUM_W-1:0]} + {{(SUM_W - 2){1'b0}}, x[WIDE_W-1:SUM_W]};
        s2 = {1'b0, s1[SUM_W-1:0]} + {{SUM_W{1'b0}}, s1[SUM_W]};
        return s2[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/swrc_chan_if.sv */
`default_nettype none

interface swrc_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/swrc_in_reg.sv */
`default_nettype none

module swrc_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire swrc_pkg::t_in_word i_word,
    output logic                   o_valid,
    input  wire logic              i_take,
    output swrc_pkg::t_in_word     o_word
);
    import swrc_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // The register refills in the same cycle that its word moves on.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

/* rtl/swrc_proc.sv */
`default_nettype none
`include "stop_wait_receiver_checksum_unit_macros.svh"

module swrc_proc #(
    parameter int unsigned MAX_PAYLOAD_BYTES = swrc_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_take,
    input  wire swrc_pkg::t_in_word i_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output swrc_pkg::t_out_word     o_word
);
    import swrc_pkg::*;

    // The byte count field cannot exceed 2047, so the limit is capped there.
    localparam int unsigned CNT_FIELD_MAX = (1 << COUNT_W) - 1;
    localparam int unsigned EFF_MAX   = (MAX_PAYLOAD_BYTES < CNT_FIELD_MAX) ?
                                        MAX_PAYLOAD_BYTES : CNT_FIELD_MAX;
    localparam int unsigned WORDS_MAX = (EFF_MAX + 1) / 2;
    localparam int unsigned IDX_W     = $clog2(WORDS_MAX + 1);
    localparam logic [16:0]        CNT_LIMIT = 17'(MAX_PAYLOAD_BYTES);
    localparam logic [COUNT_W-1:0] CNT_CAP   = COUNT_W'(EFF_MAX);

    logic [SUM_W-1:0]   r_exp_seq;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   r_held_seq;
    logic [COUNT_W-1:0] r_held_count;
    logic [IDX_W-1:0]   r_idx;
    logic               r_out_valid;
    t_out_word          r_out;

    logic               w_take;
    logic [WIDE_W-1:0]  w_hdr_wide;
    logic [WIDE_W-1:0]  w_base;
    logic [COUNT_W-1:0] w_cnt_sel;
    logic [COUNT_W-1:0] w_eff;
    logic [COUNT_W:0]   w_eff_p1;
    logic [COUNT_W-1:0] w_words;
    logic [IDX_W-1:0]   w_idx_base;
    logic [COUNT_W-1:0] w_idx_ext;
    logic               w_use_data;
    logic               w_odd_tail;
    logic [SUM_W-1:0]   w_dword;
    logic [WIDE_W-1:0]  w_sum_wide;
    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]   w_seq_sel;
    logic               w_commit;
    t_out_word          n_out;
    logic [SUM_W-1:0]   n_exp_seq;
    logic [SUM_W-1:0]   n_sum;
    logic [IDX_W-1:0]   n_idx;

    assign w_take  = i_valid && (!r_out_valid || i_ready);
    assign o_take  = w_take;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_comb begin
        // Header words of a new packet, or the sum carried from earlier words.
        w_hdr_wide = {3'b0, i_word.pkt_seq} + {3'b0, i_word.sync_word}
                   + {3'b0, i_word.ack_word} + {8'b0, i_word.byte_count}
                   + {3'b0, i_word.check_word} + {3'b0, i_word.retry_word};
        w_base     = i_word.first_item ? w_hdr_wide : {3'b0, r_sum};
        w_cnt_sel  = i_word.first_item ? i_word.byte_count : r_held_count;
        w_seq_sel  = i_word.first_item ? i_word.pkt_seq : r_held_seq;
        w_idx_base = i_word.first_item ? '0 : r_idx;

        w_eff      = ({6'b0, w_cnt_sel} > CNT_LIMIT) ? CNT_CAP : w_cnt_sel;
        w_eff_p1   = {1'b0, w_eff} + {{COUNT_W{1'b0}}, 1'b1};
        w_words    = w_eff_p1[COUNT_W:1];
        w_idx_ext  = {{(COUNT_W - IDX_W){1'b0}}, w_idx_base};

        // Words past the announced count are neither summed nor passed on.
        w_use_data = i_word.data_valid && (w_idx_ext < w_words);
        w_odd_tail = w_eff[0] && ((w_idx_ext + {{(COUNT_W - 1){1'b0}}, 1'b1}) == w_words);
        w_dword    = w_odd_tail ? (i_word.data_word & ODD_MASK) : i_word.data_word;

        w_sum_wide = w_base + (w_use_data ? {3'b0, w_dword} : '0);
        w_sum      = fold_sum(w_sum_wide);
        n_idx      = w_use_data ? (w_idx_base + {{(IDX_W - 1){1'b0}}, 1'b1}) : w_idx_base;

        n_out                = '0;
        n_out.data_out       = w_use_data ? w_dword : '0;
        n_out.data_out_valid = w_use_data;
        n_out.packet_end     = i_word.last_item;
        n_out.verdict        = V_COMMIT;
        w_commit             = 1'b0;

        if (i_word.last_item) begin
            priority if (w_sum != SUM_ONES) begin
                n_out.verdict   = V_CSUM_ERR;
                n_out.ack_valid = 1'b1;
                n_out.ack_seq   = r_exp_seq - 16'd1;
            end else if (w_seq_sel == r_exp_seq) begin
                n_out.verdict   = V_COMMIT;
                n_out.ack_valid = 1'b1;
                n_out.ack_seq   = w_seq_sel;
                w_commit        = 1'b1;
            end else if (w_seq_sel < r_exp_seq) begin
                n_out.verdict   = V_DUP;
                n_out.ack_valid = 1'b1;
                n_out.ack_seq   = w_seq_sel;
            end else begin
                n_out.verdict   = V_AHEAD;
            end
        end

        n_exp_seq = w_commit ? (r_exp_seq + 16'd1) : r_exp_seq;
        n_sum     = i_word.last_item ? '0 : w_sum;
        if (i_word.last_item) begin
            n_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_seq    <= SEQ_RESET;
            r_sum        <= '0;
            r_held_seq   <= '0;
            r_held_count <= '0;
            r_idx        <= '0;
        end else if (w_take) begin
            r_exp_seq    <= n_exp_seq;
            r_sum        <= n_sum;
            r_held_seq   <= w_seq_sel;
            r_held_count <= w_cnt_sel;
            r_idx        <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    `SWRC_ASSERT_ALWAYS(a_reset_seq, i_clk, !i_rst_n |=> (r_exp_seq == SEQ_RESET))
    `SWRC_ASSERT(a_commit_adv, i_clk, i_rst_n,
        (w_take && w_commit) |=> (r_exp_seq == $past(r_exp_seq) + 16'd1))
    `SWRC_ASSERT(a_idle_hold, i_clk, i_rst_n,
        !w_take |=> ($stable(r_exp_seq) && $stable(r_sum) && $stable(r_idx)))
    `SWRC_ASSERT(a_end_clear, i_clk, i_rst_n,
        (w_take && i_word.last_item) |=> ((r_sum == '0) && (r_idx == '0)))
    `SWRC_ASSERT(a_idx_bound, i_clk, i_rst_n, ({{(32 - IDX_W){1'b0}}, r_idx} <= WORDS_MAX))

endmodule

`default_nettype wire

/* rtl/stop_wait_receiver_checksum_unit.sv */
// Receiving side of a stop-and-wait transfer with a 16-bit ones' complement
// checksum. Words arrive on i_in: a word with first_item set carries the six
// header fields of a packet, any word may carry one payload word, and the word
// with last_item set closes the packet. One result word leaves on o_out for
// every input word: the payload word passed through (tentative until the
// packet ends) and, on the closing word, the verdict and acknowledgement.
// Throughput is one word per cycle while o_out.ready stays high. The accepting
// edge loads the input register, and the word moves on into the result register
// once that register is free; the checksum add, fold and sequence compare lie
// between the two registers.
// The running sum, held header and word count loop back within the one
// stage ahead of the result register, which is what sets the one-cycle rate.
// A synchronous active-low reset empties both registers, clears the sum and
// sets the expected sequence to one. When the consumer holds o_out.ready low,
// the result register holds its word; the input register still takes one more
// word, and i_in.ready falls only once both are full.
`default_nettype none

module stop_wait_receiver_checksum_unit #(
    parameter int unsigned MAX_PAYLOAD_BYTES = swrc_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    swrc_chan_if.sink   i_in,
    swrc_chan_if.source o_out
);
    import swrc_pkg::*;

    logic      w_stage_valid;
    logic      w_stage_take;
    t_in_word  w_stage_word;
    t_out_word w_out_word;

    // Input register: decouples the upstream side from the result register.
    swrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_word  (i_in.payload),
        .o_valid (w_stage_valid),
        .i_take  (w_stage_take),
        .o_word  (w_stage_word)
    );

    // Checksum, verdict and sequence tracking, ending in the result register.
    swrc_proc #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_proc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_stage_valid),
        .o_take  (w_stage_take),
        .i_word  (w_stage_word),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_word  (w_out_word)
    );

    assign o_out.payload = w_out_word;

endmodule

`default_nettype wire

/* bench/tb_stop_wait_receiver_checksum_unit.sv */
// Self-checking bench for the stop-and-wait receiver. Every input word that the
// block accepts is run through a behavioral copy of the receiver kept in this
// module. The copy holds its own expected sequence, running ones' complement
// sum and held header. The result word it predicts is queued, and the
// monitor compares each word leaving o_out, field by field, against the
// oldest entry of that queue.
module tb_stop_wait_receiver_checksum_unit;
    import swrc_pkg::*;

    localparam int unsigned PAYLOAD_LIMIT = MAX_PAYLOAD_BYTES_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    swrc_chan_if #(.t_payload(t_in_word))  in_if ();
    swrc_chan_if #(.t_payload(t_out_word)) out_if ();

    stop_wait_receiver_checksum_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    // State of the behavioral receiver. It follows the block's reset values.
    logic [15:0]        next_seq    = SEQ_RESET;
    logic [15:0]        sum_acc     = '0;
    logic [15:0]        hdr_seq     = '0;
    logic [COUNT_W-1:0] hdr_count   = '0;
    int unsigned        words_taken = 0;

    // Result words still owed by the block, oldest first.
    t_out_word   pending_results[$];
    t_out_word   oldest_result;
    int unsigned error_count = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;

    // Ready pattern of the result side. It rotates every cycle and is
    // replaced by a new random pattern once its age counter runs out.
    logic [15:0] ready_pattern = 16'hffff;
    int unsigned pattern_age   = 0;

    // A 16-bit add with the carry out folded back in. Two 16-bit terms can
    // never carry twice, so one fold is enough.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Applies one accepted word to the behavioral receiver and queues the
    // result word that it must produce. The header is taken first, then the
    // payload word, then the verdict, as the block does within one word.
    function automatic void predict_result(input t_in_word w);
        t_out_word   r;
        logic [15:0] hsum;
        logic [15:0] pw;
        int unsigned eff;
        int unsigned nwords;
        r = '0;
        if (w.first_item) begin
            // The raw count goes into the sum even when it exceeds the limit.
            hsum = ones_add(16'd0, w.pkt_seq);
            hsum = ones_add(hsum, w.sync_word);
            hsum = ones_add(hsum, w.ack_word);
            hsum = ones_add(hsum, 16'(w.byte_count));
            hsum = ones_add(hsum, w.check_word);
            sum_acc = ones_add(hsum, w.retry_word);
            hdr_seq = w.pkt_seq;
            hdr_count = w.byte_count;
            words_taken = 0;
        end
        if (w.data_valid) begin
            eff = (hdr_count > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : hdr_count;
            nwords = (eff + 1) / 2;
            // Surplus payload is neither summed nor passed through.
            if (words_taken < nwords) begin
                pw = w.data_word;
                if ((eff % 2) == 1 && words_taken + 1 == nwords) begin
                    pw = pw & ODD_MASK;
                end
                sum_acc = ones_add(sum_acc, pw);
                words_taken++;
                r.data_out = pw;
                r.data_out_valid = 1'b1;
            end
        end
        if (w.last_item) begin
            r.packet_end = 1'b1;
            if (sum_acc != SUM_ONES) begin
                r.verdict = V_CSUM_ERR;
                r.ack_valid = 1'b1;
                r.ack_seq = next_seq - 16'd1;
            end else if (hdr_seq == next_seq) begin
                r.verdict = V_COMMIT;
                r.ack_valid = 1'b1;
                r.ack_seq = hdr_seq;
                next_seq = next_seq + 16'd1;
            end else if (hdr_seq < next_seq) begin
                // Plain unsigned compare: once the sequence wraps to zero,
                // nothing counts as older any more.
                r.verdict = V_DUP;
                r.ack_valid = 1'b1;
                r.ack_seq = hdr_seq;
            end else begin
                r.verdict = V_AHEAD;
            end
            sum_acc = '0;
            words_taken = 0;
        end
        pending_results.push_back(r);
    endfunction

    function automatic t_in_word random_word();
        t_in_word     w;
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        w = raw[$bits(t_in_word)-1:0];
        return w;
    endfunction

    function automatic void report_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        error_count++;
    endfunction

    // Result monitor. Handshake signals are sampled at the edge, before the
    // block's registers move.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h",
                         $time, out_if.payload);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (out_if.payload.data_out !== oldest_result.data_out)
                    report_field("data_out", oldest_result.data_out,
                                 out_if.payload.data_out);
                if (out_if.payload.data_out_valid !== oldest_result.data_out_valid)
                    report_field("data_out_valid", 16'(oldest_result.data_out_valid),
                                 16'(out_if.payload.data_out_valid));
                if (out_if.payload.packet_end !== oldest_result.packet_end)
                    report_field("packet_end", 16'(oldest_result.packet_end),
                                 16'(out_if.payload.packet_end));
                if (out_if.payload.verdict !== oldest_result.verdict)
                    report_field("verdict", 16'(oldest_result.verdict),
                                 16'(out_if.payload.verdict));
                if (out_if.payload.ack_valid !== oldest_result.ack_valid)
                    report_field("ack_valid", 16'(oldest_result.ack_valid),
                                 16'(out_if.payload.ack_valid));
                if (out_if.payload.ack_seq !== oldest_result.ack_seq)
                    report_field("ack_seq", oldest_result.ack_seq,
                                 out_if.payload.ack_seq);
            end
        end
    end

    // The consumer holds ready low on its own pattern. A quarter of the
    // patterns never stall; the rest keep bits 0 and 8 set, so every rotation
    // of such a pattern still brings ready high twice.
    always @(posedge i_clk) begin
        if (pattern_age == 0) begin
            pattern_age <= $urandom_range(20, 80);
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff
                                                          : (16'($urandom) | 16'h0101);
        end else begin
            pattern_age <= pattern_age - 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        out_if.ready <= ready_pattern[0];
    end

    // Sends one word and returns at the edge where it is accepted. The sender
    // works in bursts; a gap of idle cycles may open before a new burst. Valid
    // stays high across back-to-back words and is only lowered for a gap.
    task automatic send_word(input t_in_word w);
        int unsigned gap_cycles;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_cycles != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap_cycles) @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b1;
        in_if.payload <= w;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_result(w);
        burst_left--;
        items_sent++;
    endtask

    // Sends one packet of nwords payload words under a header that claims
    // count bytes. The check word is chosen so that the packet sums to all
    // ones, unless corrupt is set. With tight set every word carries payload
    // and the last payload word closes the packet; otherwise words without
    // payload are mixed in. With closed clear the packet never gets its last
    // word. Header fields on words after the first are random noise.
    task automatic send_packet(input logic [15:0] seq, input int unsigned count,
                               input int unsigned nwords, input bit corrupt,
                               input bit tight, input bit closed);
        t_in_word    w;
        logic [15:0] words[$];
        logic [15:0] csum;
        logic [15:0] d;
        int unsigned eff;
        int unsigned limit_words;
        int unsigned sent;
        bit          started;
        eff = (count > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : count;
        limit_words = (eff + 1) / 2;
        w = random_word();
        w.pkt_seq = seq;
        w.byte_count = COUNT_W'(count);
        csum = ones_add(16'd0, seq);
        csum = ones_add(csum, w.sync_word);
        csum = ones_add(csum, w.ack_word);
        csum = ones_add(csum, 16'(w.byte_count));
        csum = ones_add(csum, w.retry_word);
        for (int k = 0; k < nwords; k++) begin
            d = 16'($urandom);
            words.push_back(d);
            // Only the words within the clamped length count, and an odd
            // final word counts with its low byte cleared.
            if (k < limit_words) begin
                if ((eff % 2) == 1 && k + 1 == limit_words) d = d & ODD_MASK;
                csum = ones_add(csum, d);
            end
        end
        w.check_word = ~csum;
        if (corrupt) w.check_word = w.check_word ^ 16'($urandom_range(1, 65535));
        sent = 0;
        started = 1'b0;
        forever begin
            if (started) w = random_word();
            w.first_item = !started;
            w.data_valid = 1'b0;
            w.last_item = 1'b0;
            if (sent < nwords && (tight || $urandom_range(0, 7) != 0)) begin
                w.data_valid = 1'b1;
                w.data_word = words[sent];
                sent++;
            end
            if (sent == nwords) begin
                w.last_item = closed && (tight || $urandom_range(0, 3) != 0);
            end
            send_word(w);
            started = 1'b1;
            if (sent == nwords && (w.last_item || !closed)) break;
        end
    endtask

    task automatic reset_block();
        in_if.valid = 1'b0;
        in_if.payload = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Two single-word packets with every field at its top and at its bottom.
    task automatic test_field_extremes();
        t_in_word w;
        w = '1;
        send_word(w);
        w = '0;
        w.first_item = 1'b1;
        w.last_item = 1'b1;
        send_word(w);
    endtask

    // One packet for each verdict: in order, stale, far ahead and damaged.
    task automatic test_each_verdict();
        send_packet(next_seq, 4, 2, 1'b0, 1'b1, 1'b1);
        send_packet(next_seq - 16'd1, 3, 2, 1'b0, 1'b1, 1'b1);
        send_packet(next_seq + 16'd7, 0, 0, 1'b0, 1'b1, 1'b1);
        send_packet(next_seq, 2, 1, 1'b1, 1'b1, 1'b1);
    endtask

    // Surplus words, missing words, an odd single byte, and counts above the
    // payload limit, one of them odd while its clamped length is even.
    task automatic test_payload_edges();
        send_packet(next_seq, 2, 4, 1'b0, 1'b1, 1'b1);
        send_packet(next_seq, 6, 1, 1'b0, 1'b1, 1'b1);
        send_packet(next_seq, 1, 1, 1'b0, 1'b1, 1'b1);
        send_packet(next_seq, 1500, 3, 1'b0, 1'b1, 1'b1);
        send_packet(next_seq, 1025, 2, 1'b0, 1'b1, 1'b1);
    endtask

    // A packet cut short by a new header, then words with no header at all,
    // which run on from the cleared sum and the last header held.
    task automatic test_missing_header();
        t_in_word w;
        send_packet(next_seq, 4, 2, 1'b0, 1'b1, 1'b0);
        send_packet(next_seq, 0, 0, 1'b0, 1'b1, 1'b1);
        for (int k = 0; k < 3; k++) begin
            w = random_word();
            w.first_item = 1'b0;
            w.data_valid = 1'b1;
            w.last_item = (k == 2);
            send_word(w);
        end
    endtask

    // The longest packet: a full odd one whose final word loses its low byte,
    // followed by two words of surplus.
    task automatic test_full_payload();
        send_packet(next_seq, 1023, 514, 1'b0, 1'b1, 1'b1);
    endtask

    // Mostly well-formed packets with random content, so that commits keep
    // moving the expected sequence, mixed with stale, early and damaged
    // packets, packets left open, stray words and fully random words.
    task automatic test_random_traffic();
        t_in_word    w;
        int unsigned target;
        int unsigned kind;
        int unsigned pick;
        int unsigned count;
        int unsigned full_words;
        int unsigned nwords;
        logic [15:0] seq;
        target = items_sent + 160;
        while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (pick < 80) count = $urandom_range(0, 16);
            else if (pick < 95) count = $urandom_range(17, 80);
            else count = $urandom_range(1000, 2047);
            full_words = (((count > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : count) + 1) / 2;
            pick = $urandom_range(0, 9);
            if (count >= 1000) nwords = $urandom_range(0, 4);
            else if (pick == 7) nwords = $urandom_range(0, full_words);
            else if (pick == 8) nwords = full_words + $urandom_range(1, 3);
            else nwords = full_words;
            pick = $urandom_range(0, 99);
            if (pick < 65) seq = next_seq;
            else if (pick < 75) seq = next_seq - 16'($urandom_range(1, 3));
            else if (pick < 85) seq = next_seq + 16'($urandom_range(1, 1000));
            else seq = 16'($urandom);
            if (kind < 75) begin
                send_packet(seq, count, nwords, $urandom_range(0, 9) == 0, 1'b0, 1'b1);
            end else if (kind < 85) begin
                send_packet(seq, count, nwords, 1'b0, 1'b0, 1'b0);
            end else if (kind < 93) begin
                repeat ($urandom_range(1, 4)) begin
                    w = random_word();
                    w.first_item = 1'b0;
                    w.last_item = ($urandom_range(0, 2) == 0);
                    send_word(w);
                end
            end else begin
                send_word(random_word());
            end
        end
    endtask

    // Waits for every owed result, then keeps watching so that a stray
    // word from the two-stage pipeline would still be caught.
    task automatic finish_run();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_stop_wait_receiver_checksum_unit: clean");
        end else begin
            $display("tb_stop_wait_receiver_checksum_unit: errors");
        end
        $finish;
    endtask

    initial begin
        reset_block();
        test_field_extremes();
        test_each_verdict();
        test_payload_edges();
        test_missing_header();
        test_full_payload();
        test_random_traffic();
        finish_run();
    end

    // About 750 words at most; this bound covers every word meeting both the
    // longest send gap and the longest consumer stall, several times over.
    initial begin
        #200000;
        $display("tb_stop_wait_receiver_checksum_unit: errors");
        $finish;
    end
endmodule
